### rtl/sha1_pkg.sv
// SHA-1 hash unit shared types and constants.
package sha1_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned LEN_FILL = 56;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       put;        // write put_byte at fill position
    logic [7:0] put_byte;
    logic       count_inc;
    logic       put_len;    // write length words 14 and 15
    logic       comp_start; // load round registers from chaining value
    logic       round_en;   // run one round
    logic       comp_done;  // add round registers into chaining value
    logic       fill_clr;
    logic       restore;    // reload initial value, clear count
  } dp_cmd_t;

  typedef struct packed {
    logic [6:0] fill;
    logic [6:0] round;
  } dp_stat_t;

endpackage

### rtl/sha1_datapath.sv
// SHA-1 datapath: block window, round registers, chaining value, counters.
module sha1_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sha1_pkg::dp_cmd_t  cmd,
  input  logic [2:0]         rd_sel,
  output logic [31:0]        rd_word,
  output sha1_pkg::dp_stat_t stat
);

  logic [31:0] win_r [16];
  logic [31:0] cv_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  fill_r, round_r;
  logic [60:0] cnt_r;

  logic [3:0]  t4, wi, f4;
  logic [31:0] wx, wsched, wcur, f, k, tmp, mask, shifted;
  logic [4:0]  sh;

  assign t4 = round_r[3:0];
  assign wx = win_r[4'(t4 + 4'd13)] ^ win_r[4'(t4 + 4'd8)] ^
              win_r[4'(t4 + 4'd2)] ^ win_r[t4];
  assign wsched = {wx[30:0], wx[31]};
  assign wcur = (round_r >= 7'd16) ? wsched : win_r[t4];

  always_comb begin
    if (round_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = sha1_pkg::K0;
    end else if (round_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = sha1_pkg::K1;
    end else if (round_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = sha1_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = sha1_pkg::K3;
    end
  end
  assign tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + wcur;

  assign f4 = fill_r[5:2];
  assign sh = {2'd3 - fill_r[1:0], 3'd0};
  assign mask = (fill_r[1:0] == 2'd0) ? 32'd0 : ~(32'hFF << sh);
  assign shifted = {24'd0, cmd.put_byte} << sh;
  assign wi = f4;

  always_ff @(posedge clk) begin
    if (cmd.put) win_r[wi] <= (win_r[wi] & mask) | shifted;
    if (cmd.put_len) begin
      win_r[14] <= cnt_r[60:29];
      win_r[15] <= {cnt_r[28:0], 3'd0};
    end
    if (cmd.round_en && round_r >= 7'd16) win_r[t4] <= wsched;
    if (cmd.comp_start) begin
      a_r <= cv_r[0]; b_r <= cv_r[1]; c_r <= cv_r[2]; d_r <= cv_r[3]; e_r <= cv_r[4];
    end else if (cmd.round_en) begin
      e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= tmp;
    end
    if (!rst_n) begin
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restore) begin
      cv_r[0] <= sha1_pkg::H0; cv_r[1] <= sha1_pkg::H1; cv_r[2] <= sha1_pkg::H2;
      cv_r[3] <= sha1_pkg::H3; cv_r[4] <= sha1_pkg::H4;
    end else if (cmd.comp_done) begin
      cv_r[0] <= cv_r[0] + a_r; cv_r[1] <= cv_r[1] + b_r; cv_r[2] <= cv_r[2] + c_r;
      cv_r[3] <= cv_r[3] + d_r; cv_r[4] <= cv_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0; round_r <= '0; cnt_r <= '0;
    end else begin
      if (cmd.fill_clr) fill_r <= '0;
      else if (cmd.put) fill_r <= fill_r + 7'd1;
      if (cmd.restore) cnt_r <= '0;
      else if (cmd.count_inc) cnt_r <= cnt_r + 61'd1;
      if (cmd.comp_start) round_r <= '0;
      else if (cmd.round_en) round_r <= (round_r == 7'd79) ? 7'd0 : round_r + 7'd1;
    end
  end

  assign rd_word = cv_r[rd_sel];
  assign stat.fill = fill_r;
  assign stat.round = round_r;

endmodule

### rtl/sha1_ctrl.sv
// SHA-1 controller: accepts beats, sequences padding, rounds and digest output.
module sha1_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha1_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_idx,
  output sha1_pkg::dp_cmd_t  cmd,
  input  sha1_pkg::dp_stat_t stat
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ROUND = 6'b000100,
    S_ADD   = 6'b001000,
    S_PAD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic       end_r, end_nxt, padded_r, padded_nxt, final_r, final_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = idx_r;

  always_comb begin
    state_nxt = state_r; end_nxt = end_r; padded_nxt = padded_r;
    final_nxt = final_r; idx_nxt = idx_r; cmd = '0;
    unique case (state_r)
      S_IDLE: if (acc) begin
        end_nxt = in_data.end_of_message; padded_nxt = 1'b0; final_nxt = 1'b0;
        if (in_data.byte_present) begin
          cmd.put = 1'b1; cmd.put_byte = in_data.message_byte; cmd.count_inc = 1'b1;
          if (stat.fill == 7'd63) state_nxt = S_LOAD;
          else if (in_data.end_of_message) state_nxt = S_PAD;
        end else if (in_data.end_of_message) state_nxt = S_PAD;
      end
      S_PAD: begin
        if (stat.fill == 7'(sha1_pkg::LEN_FILL) && padded_r) begin
          cmd.put_len = 1'b1; cmd.fill_clr = 1'b1; final_nxt = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          cmd.put = 1'b1;
          cmd.put_byte = padded_r ? 8'd0 : sha1_pkg::PAD_BYTE;
          padded_nxt = 1'b1;
          if (stat.fill == 7'd63) state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin cmd.comp_start = 1'b1; cmd.fill_clr = 1'b1; state_nxt = S_ROUND; end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round == 7'd79) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.comp_done = 1'b1; idx_nxt = 3'd0;
        if (final_r) state_nxt = S_OUT;
        else if (end_r) state_nxt = S_PAD;
        else state_nxt = S_IDLE;
      end
      S_OUT: if (out_ready) begin
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd4) begin
          cmd.restore = 1'b1; end_nxt = 1'b0; idx_nxt = 3'd0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; end_r <= 1'b0; padded_r <= 1'b0; final_r <= 1'b0; idx_r <= '0;
    end else begin
      state_r <= state_nxt; end_r <= end_nxt; padded_r <= padded_nxt;
      final_r <= final_nxt; idx_r <= idx_nxt;
    end
  end

endmodule

### rtl/sha1_message_hash_unit.sv
// SHA-1 message hash unit top level.
// channel | dir | payload                           | handshake
// in      | in  | message_byte, byte_present, end   | in_valid / in_ready
// out     | out | digest_word, word_index, last_word| out_valid / out_ready
// A data beat is taken only in idle; a beat that fills a block then runs
// one load, 80 rounds on the single round unit and one add.
// End of message pads one byte per cycle, then runs one or two blocks,
// then presents five digest beats, one per cycle when out_ready is high.
// rst_n is synchronous; input is held off while padding, while rounds run or while the digest waits.
module sha1_message_hash_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha1_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sha1_pkg::out_beat_t out_data
);

  sha1_pkg::dp_cmd_t  cmd;
  sha1_pkg::dp_stat_t stat;
  logic [2:0]         idx;
  logic [31:0]        word;

  sha1_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_idx(idx), .cmd, .stat
  );

  sha1_datapath u_dp (
    .clk, .rst_n, .cmd, .rd_sel(idx), .rd_word(word), .stat
  );

  assign out_data.digest_word = word;
  assign out_data.word_index  = idx;
  assign out_data.last_word   = (idx == 3'd4);

endmodule

### tb/tb_top.sv
// Testbench for the SHA-1 message hash unit: directed and random byte streams checked against a local model.
`timescale 1ns / 100ps
module tb_top;

  class digest_board;
    logic [31:0] cv[5];
    logic [31:0] win[16];
    int unsigned fill;
    logic [60:0] nbytes;
    sha1_pkg::out_beat_t pending[$];
    int errors;

    function void clear();
      cv[0] = sha1_pkg::H0; cv[1] = sha1_pkg::H1; cv[2] = sha1_pkg::H2;
      cv[3] = sha1_pkg::H3; cv[4] = sha1_pkg::H4;
      fill = 0;
      nbytes = '0;
      for (int i = 0; i < 16; i++) win[i] = '0;
    endfunction

    function void compress();
      logic [31:0] r[5];
      logic [31:0] w, f, k, tmp;
      for (int i = 0; i < 5; i++) r[i] = cv[i];
      for (int t = 0; t < 80; t++) begin
        if (t >= 16) begin
          w = win[(t - 3) & 15] ^ win[(t - 8) & 15] ^ win[(t - 14) & 15] ^ win[t & 15];
          win[t & 15] = {w[30:0], w[31]};
        end
        w = win[t & 15];
        if (t < 20) begin
          f = (r[1] & r[2]) | (~r[1] & r[3]); k = sha1_pkg::K0;
        end else if (t < 40) begin
          f = r[1] ^ r[2] ^ r[3]; k = sha1_pkg::K1;
        end else if (t < 60) begin
          f = (r[1] & r[2]) | (r[1] & r[3]) | (r[2] & r[3]); k = sha1_pkg::K2;
        end else begin
          f = r[1] ^ r[2] ^ r[3]; k = sha1_pkg::K3;
        end
        tmp = {r[0][26:0], r[0][31:27]} + f + r[4] + k + w;
        r[4] = r[3]; r[3] = r[2]; r[2] = {r[1][1:0], r[1][31:2]}; r[1] = r[0]; r[0] = tmp;
      end
      for (int i = 0; i < 5; i++) cv[i] = cv[i] + r[i];
    endfunction

    function void pack(logic [7:0] b);
      if ((fill & 3) == 0) win[fill >> 2] = '0;
      win[fill >> 2] = win[fill >> 2] | (32'(b) << ((3 - (fill & 3)) * 8));
      fill++;
      if (fill >= 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_input(sha1_pkg::in_beat_t b);
      logic [63:0] bits;
      sha1_pkg::out_beat_t o;
      if (b.byte_present) begin
        pack(b.message_byte);
        nbytes = nbytes + 61'd1;
      end
      if (!b.end_of_message) return;
      bits = {nbytes, 3'b000};
      pack(sha1_pkg::PAD_BYTE);
      if (fill > sha1_pkg::LEN_FILL) while (fill != 0) pack(8'h00);
      while (fill < sha1_pkg::LEN_FILL) pack(8'h00);
      win[14] = bits[63:32];
      win[15] = bits[31:0];
      compress();
      fill = 0;
      for (int i = 0; i < 5; i++) begin
        o.digest_word = cv[i];
        o.word_index = 3'(i);
        o.last_word = (i == 4);
        pending.push_back(o);
      end
      cv[0] = sha1_pkg::H0; cv[1] = sha1_pkg::H1; cv[2] = sha1_pkg::H2;
      cv[3] = sha1_pkg::H3; cv[4] = sha1_pkg::H4;
      nbytes = '0;
    endfunction

    function void check_result(sha1_pkg::out_beat_t got);
      sha1_pkg::out_beat_t want;
      if (pending.size() == 0) begin
        report("digest beat with none expected");
        return;
      end
      want = pending.pop_front();
      if (got.digest_word !== want.digest_word) report("digest_word mismatch");
      if (got.word_index !== want.word_index) report("word_index mismatch");
      if (got.last_word !== want.last_word) report("last_word mismatch");
    endfunction

    function void report(string what);
      $display("MISMATCH %s at %0t", what, $time);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  sha1_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  sha1_pkg::out_beat_t out_data;

  digest_board board = new();
  int rx_idle_pct = 38;
  int tx_idle_pct = 38;
  bit hold_go = 0;
  bit hold = 0;

  sha1_message_hash_unit uut (.*);

  always #5 clk = ~clk;

  task automatic send_beat(logic [7:0] b, logic p, logic e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{message_byte: b, byte_present: p, end_of_message: e};
    do @(posedge clk); while (!in_ready);
    board.note_input(in_data);
  endtask

  task automatic send_message(int len);
    bit ended;
    logic e;
    ended = 0;
    for (int i = 0; i < len; i++)
      if ($urandom_range(9) == 0) send_beat(8'($urandom), 0, 0);
      else begin
        e = (i == len - 1) && ($urandom_range(1) == 1);
        send_beat(8'($urandom), 1, e);
        ended = e;
      end
    if (!ended) send_beat(8'($urandom), 0, 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  initial begin
    wait (hold_go);
    hold <= 1;
    repeat (400) @(posedge clk);
    hold <= 0;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else begin
      if (out_valid && out_ready) board.check_result(out_data);
      if (hold) out_ready <= 0;
      else out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int lens[$];
    board.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    lens = '{0, 1, 55, 56, 63, 64};
    foreach (lens[j]) begin
      for (int i = 0; i < lens[j]; i++)
        send_beat((j == 1) ? 8'hFF : (i[0] ? 8'h00 : 8'hFF), 1, 0);
      send_beat(8'hA5, 0, 0);
      send_beat(8'hFF, 0, 1);
    end
    send_beat(8'h00, 1, 1);
    send_beat(8'hFF, 1, 1);
    drain();
    hold_go = 1;
    for (int m = 0; m < 4; m++) send_message(0);
    drain();
    rx_idle_pct = 0; tx_idle_pct = 0;
    for (int m = 0; m < 3; m++) send_message($urandom_range(1, 10));
    rx_idle_pct = 38; tx_idle_pct = 38;
    for (int m = 0; m < 8; m++) send_message($urandom_range(0, 10));
    drain();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("sha1_message_hash_unit test passed");
    else
      $display("sha1_message_hash_unit test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("sha1_message_hash_unit test failed");
    $finish;
  end
endmodule

### files.f
rtl/sha1_pkg.sv
rtl/sha1_datapath.sv
rtl/sha1_ctrl.sv
rtl/sha1_message_hash_unit.sv
tb/tb_top.sv
